// ----- rtl/sli_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted leaf search/insert block.
// Used by sli_controller, sli_datapath and sorted_leaf_search_insert.
package sli_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int VALUE_BYTES_DEF = 8;

	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 64;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;

	localparam logic OP_SEARCH = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_POS_BAD = 2'd2;

	// Kind of result the datapath registers at the end of a transaction.
	typedef enum logic [2:0] {
		RSP_NONE,
		RSP_HIT,
		RSP_MISS,
		RSP_INS,
		RSP_FULL,
		RSP_POS
	} sli_rsp_t;

	typedef struct packed {
		logic     load;
		logic     probe;
		logic     compare;
		logic     shift_rd;
		logic     shift_wr;
		logic     ins_wr;
		sli_rsp_t rsp;
	} sli_cmd_t;

	typedef struct packed {
		logic op_insert;
		logic full;
		logic pos_bad;
		logic range_empty;
		logic hit;
		logic idx_at_pos;
	} sli_stat_t;

endpackage

// ----- rtl/sli_controller.sv -----
`timescale 1ns / 1ps
// Sequencer for search and insert transactions.
// Depends on sli_pkg for command and status structs.
module sli_controller import sli_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sli_stat_t stat,
	output sli_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_PROBE,
		S_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   busy_q;

	always_comb begin
		cmd       = '0;
		cmd.rsp   = RSP_NONE;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (!stat.op_insert) begin
					state_nxt = S_PROBE;
				end else if (stat.full) begin
					cmd.rsp   = RSP_FULL;
					state_nxt = S_IDLE;
				end else if (stat.pos_bad) begin
					cmd.rsp   = RSP_POS;
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_SHIFT_RD;
				end
			end
			S_PROBE: begin
				if (stat.range_empty) begin
					cmd.rsp   = RSP_MISS;
					state_nxt = S_IDLE;
				end else begin
					cmd.probe = 1'b1;
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				if (stat.hit) begin
					cmd.rsp   = RSP_HIT;
					state_nxt = S_IDLE;
				end else begin
					state_nxt = S_PROBE;
				end
			end
			S_SHIFT_RD: begin
				if (stat.idx_at_pos) begin
					state_nxt = S_INS_WR;
				end else begin
					cmd.shift_rd = 1'b1;
					state_nxt    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_nxt    = S_SHIFT_RD;
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				cmd.rsp    = RSP_INS;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			busy_q  <= (state_nxt != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// ----- rtl/sli_datapath.sv -----
`timescale 1ns / 1ps
// Key/value memories, search bounds, shift index, entry count and result registers.
// Depends on sli_pkg; driven by sli_controller commands.
module sli_datapath import sli_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       opcode,
	input  logic signed [KEY_W-1:0]    key,
	input  logic [POS_W-1:0]           position,
	input  logic [VALUE_W-1:0]         value,
	input  sli_cmd_t                   cmd,
	output sli_stat_t                  stat,
	output logic                       done,
	output logic                       found,
	output logic [POS_W-1:0]           slot,
	output logic [STATUS_W-1:0]        status,
	output logic [POS_W-1:0]           entry_count
);

	localparam int AW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int IW   = $clog2(MAX_ENTRIES + 2);
	localparam int VW   = VALUE_BYTES * 8;
	localparam int CMPW = (IW > POS_W) ? IW : POS_W;

	logic signed [KEY_W-1:0] key_mem [MAX_ENTRIES];
	logic [VW-1:0]           val_mem [MAX_ENTRIES];

	logic                    op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        pos_q;
	logic [VW-1:0]           val_q;
	logic [IW-1:0]           lo_q;
	logic [IW-1:0]           hi_q;
	logic [IW-1:0]           mid_q;
	logic [IW-1:0]           idx_q;
	logic [CW-1:0]           count_q;
	logic signed [KEY_W-1:0] rd_key_q;
	logic [VW-1:0]           rd_val_q;

	logic                    done_q;
	logic                    found_q;
	logic [POS_W-1:0]        slot_q;
	logic [STATUS_W-1:0]     status_q;
	logic [POS_W-1:0]        count_out_q;

	logic [IW:0]             sum_c;
	logic [IW-1:0]           mid_c;
	logic [IW-1:0]           mid_m1_c;
	logic [IW-1:0]           idx_m1_c;
	logic [AW-1:0]           rd_addr_c;
	logic [AW-1:0]           wr_addr_c;
	logic                    wr_en_c;
	logic signed [KEY_W-1:0] wr_key_c;
	logic [VW-1:0]           wr_val_c;
	logic                    key_eq_c;
	logic                    key_lt_c;

	assign sum_c     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c     = sum_c[IW:1];
	assign mid_m1_c  = mid_c - IW'(1);
	assign idx_m1_c  = idx_q - IW'(1);
	assign rd_addr_c = cmd.probe ? mid_m1_c[AW-1:0] : idx_m1_c[AW-1:0];
	assign wr_en_c   = cmd.shift_wr | cmd.ins_wr;
	assign wr_addr_c = cmd.ins_wr ? AW'(pos_q) : idx_q[AW-1:0];
	assign wr_key_c  = cmd.ins_wr ? key_q : rd_key_q;
	assign wr_val_c  = cmd.ins_wr ? val_q : rd_val_q;

	assign key_eq_c  = (rd_key_q == key_q);
	assign key_lt_c  = (rd_key_q < key_q);

	assign stat.op_insert   = (op_q == OP_INSERT);
	assign stat.full        = (count_q >= CW'(MAX_ENTRIES));
	assign stat.pos_bad     = (CMPW'(pos_q) > CMPW'(count_q));
	assign stat.range_empty = (lo_q > hi_q);
	assign stat.hit         = key_eq_c;
	assign stat.idx_at_pos  = (CMPW'(idx_q) == CMPW'(pos_q));

	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			key_mem[wr_addr_c] <= wr_key_c;
			val_mem[wr_addr_c] <= wr_val_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe || cmd.shift_rd) begin
			rd_key_q <= key_mem[rd_addr_c];
			rd_val_q <= val_mem[rd_addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			key_q <= key;
			pos_q <= position;
			val_q <= value[VW-1:0];
			lo_q  <= IW'(1);
			hi_q  <= IW'(count_q);
			idx_q <= IW'(count_q);
		end else begin
			if (cmd.probe) begin
				mid_q <= mid_c;
			end
			if (cmd.compare && !key_eq_c) begin
				if (key_lt_c) begin
					lo_q <= mid_q + IW'(1);
				end else begin
					hi_q <= mid_q - IW'(1);
				end
			end
			if (cmd.shift_wr) begin
				idx_q <= idx_m1_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
			slot_q      <= '0;
			status_q    <= STATUS_OK;
			count_out_q <= '0;
		end else begin
			if (cmd.ins_wr) begin
				count_q <= count_q + CW'(1);
			end
			done_q <= (cmd.rsp != RSP_NONE);
			unique case (cmd.rsp)
				RSP_HIT: begin
					found_q     <= 1'b1;
					slot_q      <= POS_W'(mid_q - IW'(1));
					status_q    <= STATUS_OK;
					count_out_q <= POS_W'(count_q);
				end
				RSP_MISS: begin
					found_q     <= 1'b0;
					slot_q      <= POS_W'(lo_q - IW'(1));
					status_q    <= STATUS_OK;
					count_out_q <= POS_W'(count_q);
				end
				RSP_INS: begin
					found_q     <= 1'b0;
					slot_q      <= pos_q;
					status_q    <= STATUS_OK;
					count_out_q <= POS_W'(count_q + CW'(1));
				end
				RSP_FULL: begin
					found_q     <= 1'b0;
					slot_q      <= '0;
					status_q    <= STATUS_FULL;
					count_out_q <= POS_W'(count_q);
				end
				RSP_POS: begin
					found_q     <= 1'b0;
					slot_q      <= '0;
					status_q    <= STATUS_POS_BAD;
					count_out_q <= POS_W'(count_q);
				end
				default: begin
					// no result this cycle: hold the last one
				end
			endcase
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign slot        = slot_q;
	assign status      = status_q;
	assign entry_count = count_out_q;

endmodule

// ----- rtl/sorted_leaf_search_insert.sv -----
`timescale 1ns / 1ps
// Top level of the sorted leaf table: binary search and positional insert.
// Depends on sli_pkg, sli_controller and sli_datapath.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------------
//  request  | start / busy       | opcode, key, position, value
//  result   | done (1-cycle)     | found, slot, status, entry_count
//
// A transaction is taken when start is high and busy is low. A search makes at
// most clog2(MAX_ENTRIES)+1 probes; each probe is one memory read plus one
// compare on the single read port. An insert moves entry_count - position
// entries: each moved entry is a read and a write of the one-read/one-write
// key and value memories. done pulses on the cycle busy drops; a new transaction
// may start that same cycle. Reset empties the table at once (count only, no
// memory sweep). The receiver cannot stall: done shows for one cycle, and found,
// slot, status and entry_count hold until the next result.
module sorted_leaf_search_insert import sli_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    opcode,
	input  logic signed [KEY_W-1:0] key,
	input  logic [POS_W-1:0]        position,
	input  logic [VALUE_W-1:0]      value,
	output logic                    done,
	output logic                    found,
	output logic [POS_W-1:0]        slot,
	output logic [STATUS_W-1:0]     status,
	output logic [POS_W-1:0]        entry_count
);

	sli_cmd_t  cmd;
	sli_stat_t stat;

	// Sequencer: walks search probes and the shift loop of an insert.
	sli_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: memories, bounds, count and the registered result.
	sli_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.VALUE_BYTES (VALUE_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.key         (key),
		.position    (position),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.found       (found),
		.slot        (slot),
		.status      (status),
		.entry_count (entry_count)
	);

`ifndef NO_ASSERTIONS
	// A result only appears as the sequencer returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted transaction always makes the block busy next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// Error results carry no match and slot zero.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (!found && slot == '0))
		else $error("error result with match or slot");

	// A result never reports more entries than the table holds.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(entry_count) <= MAX_ENTRIES))
		else $error("entry count beyond table capacity");
`endif

endmodule
